// ===== rtl/asp_pkg.sv =====
// Shared types and constants for the shelf packing atlas allocator.
`default_nettype none

package asp_pkg;

  localparam int unsigned MAX_ROWS       = 64;
  localparam int unsigned START_SIDE     = 128;
  localparam int unsigned RESET_MAX_SIDE = 4096;

  localparam int unsigned DIM_W = 15;
  localparam int unsigned POS_W = 14;
  localparam int unsigned IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);

  // floor(h / 10) == (h * 52429) >> 19 for every 15-bit h
  localparam int unsigned DIV10_MUL   = 52429;
  localparam int unsigned DIV10_MUL_W = 16;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam int unsigned PROD_W      = DIM_W + DIV10_MUL_W;
  localparam int unsigned QUOT_W      = 12;

  typedef struct packed {
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             failed;
    logic             grew;
    logic [DIM_W-1:0] side_now;
  } out_t;

  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] fill;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_GROW,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch request
    logic prep;      // divide height, restart scan
    logic scan;      // issue next row read
    logic take_row;  // place into hit row
    logic fail;      // record failure
    logic double;    // double the atlas side
    logic open_row;  // append new row
    logic emit;      // load output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;        // checked row takes the rectangle
    logic last_miss;  // last row checked and missed
    logic table_full;
    logic count_zero;
    logic need_grow;
    logic can_grow;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/asp_datapath.sv =====
// Datapath: row memory, scan pipeline, growth arithmetic and output register.
`default_nettype none

module asp_datapath
  import asp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DIM_W-1:0] cfg_wdata_i,
  input  wire in_t              in_data_i,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  output out_t                  out_data_o
);

  row_t mem [MAX_ROWS];
  row_t rd_q;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [DIM_W-1:0]  nft_q, nft_d;
  logic [DIM_W-1:0]  side_q, side_d;
  logic [DIM_W-1:0]  max_q, max_d;
  logic [CNT_W-1:0]  iss_q, iss_d;
  logic              chk_vld_q, chk_vld_d;
  logic              grew_q, grew_d;

  logic [IDX_W-1:0]  chk_idx_q;
  logic [DIM_W-1:0]  w_q, h_q;
  logic [PROD_W-1:0] prod_q;
  logic [POS_W-1:0]  res_x_q, res_y_q;
  logic              res_fail_q;
  out_t              out_q;

  logic              iss_vld;
  logic [DIM_W+3:0]  h10, hr7;
  logic              fit_h, room, hit;
  logic [QUOT_W-1:0] quot;
  logic [DIM_W:0]    rh;
  logic [DIM_W+1:0]  bottom;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  row_t              mem_wdata;

  assign iss_vld = cmd_i.scan && (iss_q < count_q);

  // Ratio test 10*h >= 7*hr and h <= hr, room test w <= side - fill (wrapping)
  assign h10   = ({4'b0, h_q} << 3) + ({4'b0, h_q} << 1);
  assign hr7   = ({4'b0, rd_q.height} << 3) - {4'b0, rd_q.height};
  assign fit_h = (h10 >= hr7) && (h_q <= rd_q.height);
  assign room  = (rd_q.fill > side_q) ||
                 (({1'b0, w_q} + {1'b0, rd_q.fill}) <= {1'b0, side_q});
  assign hit   = chk_vld_q && fit_h && room;

  assign quot   = prod_q[DIV10_SHIFT +: QUOT_W];
  assign rh     = {1'b0, h_q} + {{(DIM_W+1-QUOT_W){1'b0}}, quot};
  assign bottom = {2'b0, nft_q} + {1'b0, rh};

  assign status_o.hit        = hit;
  assign status_o.last_miss  = chk_vld_q && !hit &&
                               ((CNT_W'(chk_idx_q) + CNT_W'(1)) == count_q);
  assign status_o.table_full = (count_q >= CNT_W'(MAX_ROWS));
  assign status_o.count_zero = (count_q == '0);
  assign status_o.need_grow  = (bottom > {2'b0, side_q}) || (w_q >= side_q);
  assign status_o.can_grow   = ({side_q, 1'b0} <= {1'b0, max_q});

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_idx_q;
    mem_wdata = rd_q;
    if (cmd_i.take_row) begin
      mem_we         = 1'b1;
      mem_wdata.fill = DIM_W'({1'b0, rd_q.fill} + {1'b0, w_q});
    end else if (cmd_i.open_row) begin
      mem_we           = 1'b1;
      mem_waddr        = count_q[IDX_W-1:0];
      mem_wdata.top    = nft_q;
      mem_wdata.height = rh[DIM_W-1:0];
      mem_wdata.fill   = w_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[iss_q[IDX_W-1:0]];
  end

  always_comb begin
    count_d   = count_q;
    nft_d     = nft_q;
    side_d    = side_q;
    max_d     = max_q;
    iss_d     = iss_q;
    chk_vld_d = 1'b0;
    grew_d    = grew_q;
    if (cfg_we_i) begin
      max_d = cfg_wdata_i;
    end
    if (cmd_i.load) begin
      grew_d = 1'b0;
    end
    if (cmd_i.prep) begin
      iss_d = '0;
    end
    if (iss_vld) begin
      iss_d     = iss_q + CNT_W'(1);
      chk_vld_d = 1'b1;
    end
    if (cmd_i.double) begin
      side_d = {side_q[DIM_W-2:0], 1'b0};
      grew_d = 1'b1;
    end
    if (cmd_i.open_row) begin
      count_d = count_q + CNT_W'(1);
      nft_d   = bottom[DIM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      nft_q     <= '0;
      side_q    <= DIM_W'(START_SIDE);
      max_q     <= DIM_W'(RESET_MAX_SIDE);
      iss_q     <= '0;
      chk_vld_q <= 1'b0;
      grew_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      nft_q     <= nft_d;
      side_q    <= side_d;
      max_q     <= max_d;
      iss_q     <= iss_d;
      chk_vld_q <= chk_vld_d;
      grew_q    <= grew_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q <= in_data_i.rect_width;
      h_q <= in_data_i.rect_height;
    end
    if (cmd_i.prep) begin
      prod_q <= PROD_W'({{DIV10_MUL_W{1'b0}}, h_q} * PROD_W'(DIV10_MUL));
    end
    if (iss_vld) begin
      chk_idx_q <= iss_q[IDX_W-1:0];
    end
    if (cmd_i.take_row) begin
      res_x_q    <= rd_q.fill[POS_W-1:0];
      res_y_q    <= rd_q.top[POS_W-1:0];
      res_fail_q <= 1'b0;
    end else if (cmd_i.open_row) begin
      res_x_q    <= '0;
      res_y_q    <= nft_q[POS_W-1:0];
      res_fail_q <= 1'b0;
    end else if (cmd_i.fail) begin
      res_x_q    <= '0;
      res_y_q    <= '0;
      res_fail_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_q.pos_x    <= res_x_q;
      out_q.pos_y    <= res_y_q;
      out_q.failed   <= res_fail_q;
      out_q.grew     <= grew_q;
      out_q.side_now <= side_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/asp_ctrl.sv =====
// Controller state machine: sequences scan, growth and result hand-off.
`default_nettype none

module asp_ctrl
  import asp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = status_i.count_zero ? ST_GROW : ST_SCAN;
      end
      ST_SCAN: begin
        if (status_i.hit) begin
          state_d = ST_FINISH;
        end else if (status_i.last_miss) begin
          state_d = status_i.table_full ? ST_FINISH : ST_GROW;
        end
      end
      ST_GROW: begin
        if (!status_i.need_grow || !status_i.can_grow) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          cmd_o.take_row = 1'b1;
        end else if (status_i.last_miss && status_i.table_full) begin
          cmd_o.fail = 1'b1;
        end
      end
      ST_GROW: begin
        if (!status_i.need_grow) begin
          cmd_o.open_row = 1'b1;
        end else if (status_i.can_grow) begin
          cmd_o.double = 1'b1;
        end else begin
          cmd_o.fail = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd_o.emit = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/atlas_shelf_packer_core.sv =====
// Top level of the shelf packing texture atlas allocator.
`default_nettype none

// Channel   Direction  Handshake                   Beat
// request   in         in_valid_i / in_ready_o     in_t  {rect_width, rect_height}
// result    out        out_valid_o / out_ready_i   out_t {pos_x, pos_y, failed, grew, side_now}
// config    in         cfg_we_i                    cfg_wdata_i -> max_side
//
// One request at a time: the height is divided by ten and the rows are scanned at
// one row per cycle; if no row fits, a full table fails the request, else the side
// is doubled as needed and a new row is opened or the request fails; the result is
// loaded into the output register before the next request is accepted.
// Reset clears the row count and free height and sets the side to 128.
// A stalled result beat holds in the output register while the next request runs.

module atlas_shelf_packer_core
  import asp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_t              in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_t                  out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [DIM_W-1:0] cfg_wdata_i
);

  // Command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the state and the result valid flag
  asp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath: row memory, hit test, growth and the result register
  asp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
